// ===== hw/rtl/chd_pkg.sv =====
package chd_pkg;

  // Fixed field widths of the decoder state.
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned FIRST_W  = 17;
  localparam int unsigned OFFS_W   = 9;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned SYM_AW   = 8;
  localparam int unsigned SYM_DEPTH = 256;
  localparam int unsigned CNT_DEPTH = 16;
  localparam int unsigned CNT_AW   = 4;

  // Request codes carried by an input item.
  localparam logic [1:0] REQ_LEN_WRITE = 2'd0;
  localparam logic [1:0] REQ_SYM_WRITE = 2'd1;
  localparam logic [1:0] REQ_DATA      = 2'd2;
  localparam logic [1:0] REQ_RESTART   = 2'd3;

  // Running state of the code being assembled.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
    logic [FIRST_W-1:0] first;
    logic [OFFS_W-1:0]  offs;
  } code_state_t;

  // Outcome of one bit step.
  typedef struct packed {
    logic              match;
    logic              overflow;
    logic [SYM_AW-1:0] sym_idx;
    code_state_t       state_nxt;
  } step_res_t;

endpackage

// ===== hw/rtl/chd_sym_mem.sv =====
module chd_sym_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [chd_pkg::SYM_AW-1:0] wr_addr,
  input  logic [chd_pkg::SYM_W-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [chd_pkg::SYM_AW-1:0] rd_addr,
  output logic [chd_pkg::SYM_W-1:0]  rd_data
);

  logic [chd_pkg::SYM_W-1:0] mem [chd_pkg::SYM_DEPTH];

  // Single write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/chd_bit_unit.sv =====
module chd_bit_unit #(
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  chd_pkg::code_state_t        cur,
  input  logic                        bit_in,
  input  logic [chd_pkg::COUNT_W-1:0] count,
  output chd_pkg::step_res_t          res
);

  logic [chd_pkg::CODE_W-1:0]  code_shift;
  logic [chd_pkg::LEN_W-1:0]   len_inc;
  logic [chd_pkg::FIRST_W-1:0] code_ext;
  logic [chd_pkg::FIRST_W-1:0] count_ext;
  logic [chd_pkg::FIRST_W-1:0] diff;
  logic [chd_pkg::FIRST_W-1:0] first_sum;
  logic                        in_range;

  // Shift in the new bit and extend the length.
  assign code_shift = {cur.code[chd_pkg::CODE_W-2:0], bit_in};
  assign len_inc    = cur.len + chd_pkg::LEN_W'(1);
  assign code_ext   = {1'b0, code_shift};
  assign count_ext  = chd_pkg::FIRST_W'(count);

  // Range test against the codes of the current length.
  assign diff      = code_ext - cur.first;
  assign in_range  = (code_ext >= cur.first) && (diff < count_ext);
  assign first_sum = cur.first + count_ext;

  always_comb begin
    res.match    = in_range;
    res.overflow = !in_range && (len_inc >= chd_pkg::LEN_W'(MAX_CODE_LEN));
    res.sym_idx  = cur.offs[chd_pkg::SYM_AW-1:0] + diff[chd_pkg::SYM_AW-1:0];
    if (res.match || res.overflow) begin
      res.state_nxt = '0;
    end else begin
      res.state_nxt.code  = code_shift;
      res.state_nxt.len   = len_inc;
      res.state_nxt.first = {first_sum[chd_pkg::FIRST_W-2:0], 1'b0};
      res.state_nxt.offs  = cur.offs + count;
    end
  end

endmodule

// ===== hw/rtl/canonical_huffman_decoder_core.sv =====
// Canonical Huffman decoder. Table loads (length counts, symbols) and restarts
// are taken in the idle state. A data item is decoded one code bit per cycle,
// unless a stall holds it, by a shared compare and subtract unit: it steps
// through its bits_valid bits (eight at most) and then a final state that hands
// out the last result, and that final state waits while the output register is
// still full; the input stays not ready for that whole time. Each completed code,
// or each code that runs to MAX_CODE_LEN bits without a match, yields one result
// item; its symbol is read into a registered memory read port. A result only
// delays decoding when the output register is still full, a result is already waiting behind it and another is due.
module canonical_huffman_decoder_core #(
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_code_length,
  input  logic [8:0] in_length_count,
  input  logic [7:0] in_symbol_index,
  input  logic [7:0] in_symbol_value,
  input  logic [7:0] in_data_byte,
  input  logic [3:0] in_bits_valid,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_decoded_symbol,
  output logic       out_code_error,
  output logic       out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_FLUSH
  } state_t;

  state_t                      state_r, state_nxt;
  chd_pkg::code_state_t        cst_r, cst_nxt;
  logic [7:0]                  shreg_r, shreg_nxt;
  logic [3:0]                  bit_cnt_r, bit_cnt_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic                        pend_err_r, pend_err_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_sym_r, out_sym_nxt;
  logic                        out_err_r, out_err_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [chd_pkg::COUNT_W-1:0] count_table_r [chd_pkg::CNT_DEPTH];

  logic                        in_fire;
  logic                        out_free;
  logic [chd_pkg::LEN_W-1:0]   len_inc;
  logic [chd_pkg::COUNT_W-1:0] count_sel;
  chd_pkg::step_res_t          res;
  logic                        result_due;
  logic                        step_ok;
  logic                        mem_wr;
  logic                        mem_rd;
  logic [7:0]                  mem_rdata;
  logic [7:0]                  pend_sym;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Count for the length reached after this bit; lengths past the table count zero.
  assign len_inc = cst_r.len + chd_pkg::LEN_W'(1);
  always_comb begin
    if (len_inc >= chd_pkg::LEN_W'(1) && len_inc <= chd_pkg::LEN_W'(chd_pkg::CNT_DEPTH)) begin
      count_sel = count_table_r[len_inc[chd_pkg::CNT_AW-1:0] - chd_pkg::CNT_AW'(1)];
    end else begin
      count_sel = '0;
    end
  end

  chd_bit_unit #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_bit_unit (
    .cur   (cst_r),
    .bit_in(shreg_r[7]),
    .count (count_sel),
    .res   (res)
  );

  // A bit may step unless it would need to push a waiting result into a full output.
  assign result_due = res.match || res.overflow;
  assign step_ok    = (state_r == ST_BITS) && !(pend_valid_r && result_due && !out_free);
  assign mem_wr     = in_fire && (in_req_type == chd_pkg::REQ_SYM_WRITE);
  assign mem_rd     = step_ok && res.match;

  chd_sym_mem u_sym_mem (
    .clk    (clk),
    .wr_en  (mem_wr),
    .wr_addr(in_symbol_index),
    .wr_data(in_symbol_value),
    .rd_en  (mem_rd),
    .rd_addr(res.sym_idx),
    .rd_data(mem_rdata)
  );

  // The waiting result's symbol sits in the memory read register.
  assign pend_sym = pend_err_r ? 8'd0 : mem_rdata;

  // Sequencer: load, step one bit per cycle unless stalled by a full output, then release the final result.
  always_comb begin
    state_nxt      = state_r;
    cst_nxt        = cst_r;
    shreg_nxt      = shreg_r;
    bit_cnt_nxt    = bit_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_err_nxt   = pend_err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sym_nxt    = out_sym_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == chd_pkg::REQ_RESTART) begin
            cst_nxt = '0;
          end else if (in_req_type == chd_pkg::REQ_DATA) begin
            shreg_nxt   = in_data_byte;
            bit_cnt_nxt = (in_bits_valid > 4'd8) ? 4'd8 : in_bits_valid;
            if (in_bits_valid != 4'd0) begin
              state_nxt = ST_BITS;
            end
          end
        end
      end
      ST_BITS: begin
        if (step_ok) begin
          cst_nxt     = res.state_nxt;
          shreg_nxt   = {shreg_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r - 4'd1;
          if (result_due) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = pend_sym;
              out_err_nxt   = pend_err_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_err_nxt   = res.overflow;
          end
          if (bit_cnt_r == 4'd1) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sym_nxt    = pend_sym;
          out_err_nxt    = pend_err_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cst_r        <= '0;
      bit_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cst_r        <= cst_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    shreg_r    <= shreg_nxt;
    pend_err_r <= pend_err_nxt;
    out_sym_r  <= out_sym_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  // Length count table; writes outside lengths 1 to 16 are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < chd_pkg::CNT_DEPTH; i++) begin
        count_table_r[i] <= '0;
      end
    end else if (in_fire && in_req_type == chd_pkg::REQ_LEN_WRITE &&
                 in_code_length >= 5'd1 &&
                 in_code_length <= 5'(chd_pkg::CNT_DEPTH)) begin
      count_table_r[in_code_length[chd_pkg::CNT_AW-1:0] - chd_pkg::CNT_AW'(1)] <=
        in_length_count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_code_error     = out_err_r;
  assign out_last           = out_last_r;

  // A new item is never taken while a result of the previous one is held back.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("input ready while a result is still pending");

  // A code in progress is always shorter than the maximum length.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cst_r.len < chd_pkg::LEN_W'(MAX_CODE_LEN))
    else $error("partial code length reached the maximum");

  // While stepping bits there is always at least one bit left.
  a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BITS) |-> (bit_cnt_r != 4'd0))
    else $error("bit stepping with no bits left");

  // An error result always carries symbol zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_sym_r == 8'd0))
    else $error("error result with nonzero symbol");

endmodule
